>>> rtl/asmmg_pkg.sv
// Shared types and constants for the array sum, max, min and divisor block.
// No dependencies; imported by the controller, the datapath and the top level.
package asmmg_pkg;

  localparam int unsigned ELEMENT_BITS = 31;
  localparam int unsigned SUM_BITS     = 41;
  localparam int unsigned SHIFT_BITS   = $clog2(ELEMENT_BITS);

  typedef logic [ELEMENT_BITS-1:0] elem_t;
  typedef logic [SUM_BITS-1:0]     sum_t;
  typedef logic [SHIFT_BITS-1:0]   shift_t;

  localparam sum_t SUM_MAX = {SUM_BITS{1'b1}};

  typedef struct packed {
    logic [30:0] value;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [40:0] total;
    logic [30:0] largest;
    logic [30:0] smallest;
    logic [30:0] common_divisor;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_GCD
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;          // take the input element, start a divisor run
    logic step;          // one subtract-and-halve step
    logic commit;        // write the divisor back
    logic commit_final;  // also fill the output register and clear state
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic gcd_done;
  } dp_status_t;

endpackage

>>> rtl/asmmg_dp.sv
// Datapath: running sum, maximum, minimum, divisor, the binary divisor loop
// and the output register. Depends on asmmg_pkg; driven by asmmg_ctrl.
module asmmg_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  asmmg_pkg::in_item_t   in_item_i,
  input  asmmg_pkg::dp_cmd_t    cmd_i,
  output asmmg_pkg::dp_status_t status_o,
  output asmmg_pkg::out_item_t  out_item_o
);
  import asmmg_pkg::*;

  sum_t      sum_q, sum_d;
  elem_t     max_q, max_d;
  elem_t     min_q, min_d;
  elem_t     gcd_q, gcd_d;
  logic      first_q, first_d;
  elem_t     ga_q, ga_d;
  elem_t     gb_q, gb_d;
  shift_t    k_q, k_d;
  out_item_t out_q;

  elem_t                 in_value;
  logic [SUM_BITS:0]     sum_ext;
  elem_t                 gcd_res;
  elem_t                 diff_ab;
  elem_t                 diff_ba;

  assign in_value = elem_t'(in_item_i.value);
  assign sum_ext  = {1'b0, sum_q} + {{(SUM_BITS + 1 - ELEMENT_BITS){1'b0}}, in_value};

  assign status_o.gcd_done = (ga_q == '0) || (gb_q == '0);
  assign gcd_res = ((ga_q == '0) ? gb_q : ga_q) << k_q;
  assign diff_ab = ga_q - gb_q;
  assign diff_ba = gb_q - ga_q;

  always_comb begin
    sum_d   = sum_q;
    max_d   = max_q;
    min_d   = min_q;
    gcd_d   = gcd_q;
    first_d = first_q;
    ga_d    = ga_q;
    gb_d    = gb_q;
    k_d     = k_q;
    if (cmd_i.load) begin
      if (first_q) begin
        max_d   = in_value;
        min_d   = in_value;
        first_d = 1'b0;
      end else begin
        if (in_value > max_q) max_d = in_value;
        if (in_value < min_q) min_d = in_value;
      end
      // saturate on carry out of the top bit
      sum_d = sum_ext[SUM_BITS] ? SUM_MAX : sum_ext[SUM_BITS-1:0];
      ga_d  = gcd_q;
      gb_d  = in_value;
      k_d   = '0;
    end
    if (cmd_i.step) begin
      if (!ga_q[0] && !gb_q[0]) begin
        ga_d = ga_q >> 1;
        gb_d = gb_q >> 1;
        k_d  = k_q + shift_t'(1);
      end else if (!ga_q[0]) begin
        ga_d = ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_d = gb_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_d = diff_ab >> 1;
      end else begin
        gb_d = diff_ba >> 1;
      end
    end
    if (cmd_i.commit) begin
      gcd_d = gcd_res;
    end
    if (cmd_i.commit_final) begin
      sum_d   = '0;
      max_d   = '0;
      min_d   = '0;
      gcd_d   = '0;
      first_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= '0;
      gcd_q   <= '0;
      first_q <= 1'b1;
    end else begin
      sum_q   <= sum_d;
      max_q   <= max_d;
      min_q   <= min_d;
      gcd_q   <= gcd_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ga_q <= ga_d;
    gb_q <= gb_d;
    k_q  <= k_d;
    if (cmd_i.commit_final) begin
      out_q.total          <= 41'(sum_q);
      out_q.largest        <= 31'(max_q);
      out_q.smallest       <= 31'(min_q);
      out_q.common_divisor <= 31'(gcd_res);
    end
  end

  assign out_item_o = out_q;

endmodule

>>> rtl/asmmg_ctrl.sv
// Controller: sequences input acceptance, the divisor loop and the output
// register's valid flag. Depends on asmmg_pkg; commands asmmg_dp.
module asmmg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  asmmg_pkg::dp_status_t status_i,
  output asmmg_pkg::dp_cmd_t    cmd_o
);
  import asmmg_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // output register can take a result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          last_d     = in_last_i;
          state_d    = ST_GCD;
        end
      end
      ST_GCD: begin
        if (!status_i.gcd_done) begin
          cmd_o.step = 1'b1;
        end else if (!last_q) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end else if (out_free) begin
          cmd_o.commit       = 1'b1;
          cmd_o.commit_final = 1'b1;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
        // otherwise hold until the previous result is taken
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/array_sum_max_min_gcd.sv
// Array sum, maximum, minimum and greatest common divisor over a stream.
// Input channel: in_valid_i / in_stall_o with in_item_i carrying one element
// and a last flag; a transfer happens when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with out_item_o carrying total
// (saturated at 2^41-1), largest, smallest and common_divisor; one result is
// produced per array, after the element flagged last.
// Each element is transferred, then runs through the binary divisor loop in
// the datapath, one subtract-and-halve step per cycle, about 2 x 31 steps
// at most, and then has its divisor written back; the input stalls meanwhile.
// The result is loaded into an output register as the last element's divisor
// is written back; that write-back waits while an earlier result is still
// held in the register.
// A stalled result is held; the next array's elements are still taken, and
// only the write-back of its last element waits for the register to drain.
// Reset clears the running state, so the next element starts a new array,
// and drops any pending result.
// Depends on asmmg_pkg, asmmg_ctrl and asmmg_dp.
module array_sum_max_min_gcd (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  asmmg_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output asmmg_pkg::out_item_t out_item_o
);
  import asmmg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  asmmg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  asmmg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

`ifndef ASSERT_OFF
  // an accepted element keeps the input stalled while its divisor runs
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  a_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.common_divisor == '0) |->
      (out_item_o.total == '0) && (out_item_o.largest == '0))
    else $error("zero divisor with non-zero elements");

  a_ordering: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.largest >= out_item_o.smallest) &&
      (out_item_o.common_divisor <= out_item_o.largest))
    else $error("result fields out of order");
`endif

endmodule

>>> sim/array_stats_checker.sv
`timescale 1ns / 100ps
// Checker for array_sum_max_min_gcd: watches both channels, folds every element
// into its own running sum, maximum, minimum and divisor, and compares each result.
// Depends on asmmg_pkg for the item types and the sum width.
module array_stats_checker
  import asmmg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int unsigned mismatch_count_o,
  output int unsigned results_outstanding_o
);

  sum_t        running_total;
  elem_t       running_max;
  elem_t       running_min;
  elem_t       running_divisor;
  logic        first_pending;
  out_item_t   expected_stats[$];
  int unsigned errors;

  function automatic elem_t euclid_gcd(elem_t a, elem_t b);
    elem_t r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  task automatic clear_running();
    running_total   = '0;
    running_max     = '0;
    running_min     = '0;
    running_divisor = '0;
    first_pending   = 1'b1;
  endtask

  task automatic fold_element(input in_item_t item);
    logic [SUM_BITS:0] widened;
    out_item_t         summary;
    widened       = {1'b0, running_total} +
                    {{(SUM_BITS + 1 - ELEMENT_BITS){1'b0}}, item.value};
    // saturate: once at the top, any further carry keeps it there
    running_total = widened[SUM_BITS] ? SUM_MAX : widened[SUM_BITS-1:0];
    if (first_pending) begin
      running_max   = item.value;
      running_min   = item.value;
      first_pending = 1'b0;
    end else begin
      if (item.value > running_max) running_max = item.value;
      if (item.value < running_min) running_min = item.value;
    end
    running_divisor = euclid_gcd(running_divisor, item.value);
    if (item.last) begin
      summary.total          = running_total;
      summary.largest        = running_max;
      summary.smallest       = running_min;
      summary.common_divisor = running_divisor;
      expected_stats.push_back(summary);
      clear_running();
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", field, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_running();
      expected_stats.delete();
      errors                 = 0;
      mismatch_count_o      <= 0;
      results_outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_stats.size() == 0) begin
          $error("result with no array pending: total %0d", out_item_i.total);
          errors++;
        end else begin
          check_field("total", 64'(expected_stats[0].total), 64'(out_item_i.total));
          check_field("largest", 64'(expected_stats[0].largest),
                      64'(out_item_i.largest));
          check_field("smallest", 64'(expected_stats[0].smallest),
                      64'(out_item_i.smallest));
          check_field("common_divisor", 64'(expected_stats[0].common_divisor),
                      64'(out_item_i.common_divisor));
          void'(expected_stats.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i) fold_element(in_item_i);
      results_outstanding_o <= expected_stats.size();
      mismatch_count_o      <= errors;
    end
  end

endmodule

>>> sim/array_sum_max_min_gcd_tb.sv
`timescale 1ns / 100ps
// Testbench top for array_sum_max_min_gcd: drives arrays in bursts, stalls the
// result side, and gives the verdict. Depends on asmmg_pkg and array_stats_checker.
module array_sum_max_min_gcd_tb;
  import asmmg_pkg::*;

  localparam int unsigned CLK_PERIOD_NS        = 12;
  localparam int unsigned RESET_CYCLES         = 7;
  localparam int unsigned LONG_STREAM_ELEMENTS = 1100;
  localparam int unsigned RANDOM_ELEMENTS      = 650;
  localparam int unsigned DRAIN_CYCLES         = 100;
  localparam int unsigned CYCLE_LIMIT          = 900000;
  localparam elem_t       ELEM_MAX             = '1;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PATTERN
  } stall_mode_e;

  typedef enum logic [2:0] {
    MIX_SMALL,
    MIX_MULTIPLES,
    MIX_FULL,
    MIX_EXTREMES,
    MIX_POWERS
  } value_mix_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  int unsigned mismatches;
  int unsigned results_outstanding;

  stall_mode_e stall_mode  = STALL_NONE;
  int unsigned mode_left   = 0;
  logic [15:0] stall_shape = '0;
  int unsigned burst_left  = 0;
  int unsigned elements_sent = 0;
  int unsigned cycle_count = 0;

  array_sum_max_min_gcd dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  array_stats_checker checker_inst (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_i            (in_stall),
    .in_item_i             (in_item),
    .out_valid_i           (out_valid),
    .out_stall_i           (out_stall),
    .out_item_i            (out_item),
    .mismatch_count_o      (mismatches),
    .results_outstanding_o (results_outstanding)
  );

  initial begin
    forever #(CLK_PERIOD_NS / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: switch between stall modes, each held for a randomly drawn stretch.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= STALL_NONE;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode  <= stall_mode_e'($urandom_range(0, 3));
        mode_left   <= $urandom_range(16, 400);
        stall_shape <= 16'($urandom());
      end else begin
        mode_left   <= mode_left - 1;
        stall_shape <= {stall_shape[14:0], stall_shape[15]};
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
        default:     out_stall <= stall_shape[15];
      endcase
    end
  end

  // Hold the element until it transfers, then either carry on the burst or idle.
  task automatic send_element(input elem_t value, input logic last_flag);
    int unsigned gap;
    in_valid <= 1'b1;
    in_item  <= {value, last_flag};
    do @(posedge clk); while (in_stall);
    elements_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_outstanding != 0);
  endtask

  task automatic send_random_array();
    int unsigned pick;
    int unsigned len;
    int unsigned base;
    value_mix_e  mix;
    elem_t       value;
    pick = $urandom_range(0, 9);
    len  = (pick < 6) ? $urandom_range(1, 6) :
           (pick < 9) ? $urandom_range(7, 20) : $urandom_range(21, 60);
    mix  = value_mix_e'($urandom_range(0, 4));
    base = $urandom_range(1, 5000);
    for (int unsigned i = 0; i < len; i++) begin
      case (mix)
        MIX_SMALL:     value = elem_t'($urandom_range(0, 20));
        MIX_MULTIPLES: value = elem_t'(base * $urandom_range(0, 400000));
        MIX_FULL:      value = elem_t'($urandom());
        MIX_EXTREMES: begin
          case ($urandom_range(0, 2))
            0:       value = '0;
            1:       value = ELEM_MAX;
            default: value = ELEM_MAX - elem_t'($urandom_range(1, 3));
          endcase
        end
        default:       value = elem_t'(1) << $urandom_range(0, 30);
      endcase
      // stray element to break up the pattern now and then
      if ($urandom_range(0, 15) == 0) value = elem_t'($urandom());
      send_element(value, i == len - 1);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-element arrays at the extremes
    send_element('0, 1'b1);
    send_element(ELEM_MAX, 1'b1);
    send_element(elem_t'(1), 1'b1);
    // all zeros: divisor stays zero
    send_element('0, 1'b0);
    send_element('0, 1'b0);
    send_element('0, 1'b1);
    send_element(elem_t'(12), 1'b0);
    send_element(elem_t'(18), 1'b0);
    send_element(elem_t'(30), 1'b1);
    // leading zero must still seed the maximum and minimum
    send_element('0, 1'b0);
    send_element(elem_t'(15), 1'b0);
    send_element('0, 1'b0);
    send_element(elem_t'(25), 1'b1);
    send_element(ELEM_MAX, 1'b0);
    send_element(elem_t'(1), 1'b1);
    send_element(elem_t'(7), 1'b0);
    send_element('0, 1'b1);
    send_element(elem_t'(1) << 30, 1'b0);
    send_element(elem_t'(1) << 20, 1'b1);
    send_element(elem_t'(1000000007), 1'b0);
    send_element(elem_t'(2), 1'b1);
    send_element(ELEM_MAX, 1'b0);
    send_element(ELEM_MAX, 1'b1);

    // hold off until every result is back
    wait_for_drain();

    // overlong array of near-top values: the sum saturates
    for (int unsigned i = 0; i < LONG_STREAM_ELEMENTS; i++) begin
      send_element(ELEM_MAX - elem_t'($urandom_range(0, 1000)),
                   i == LONG_STREAM_ELEMENTS - 1);
    end

    elements_sent = 0;
    while (elements_sent < RANDOM_ELEMENTS) send_random_array();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
